// ----- design/midpoint_ellipse_rasterizer_assert.svh -----
// assertion macros for the ellipse rasterizer checker
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MER_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ellipse rasterizer check failed");

// when the trigger holds, the consequence must hold in the next cycle
`define MER_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("ellipse rasterizer check failed");

`endif

// ----- design/mer_pkg.sv -----
// shared types and constants for the midpoint ellipse rasterizer
package mer_pkg;

	localparam int DEC_BITS = 48;

	typedef logic [DEC_BITS-1:0] dec_t;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	localparam logic [1:0] LAST_IDX = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQA,
		ST_SQB,
		ST_AB,
		ST_INIT,
		ST_R1L,
		ST_R1R,
		ST_R1C,
		ST_R1B,
		ST_R1D,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_T4,
		ST_T5,
		ST_T6,
		ST_R2A,
		ST_R2B,
		ST_R2C,
		ST_R2D,
		ST_EMIT
	} state_t;

	// operand pairs for the shared multiplier
	typedef enum logic [3:0] {
		M_A_A,
		M_B_B,
		M_AA_B,
		M_BB_X1,
		M_AA_2YM1,
		M_BB_2X3,
		M_AA_YM1,
		M_TX_TX,
		M_TY_TY,
		M_BB_TMP,
		M_AA_TMP,
		M_AA_BB,
		M_AA_Y,
		M_AA_3
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_2,
		SH_3
	} acc_sh_t;

	typedef struct packed {
		logic      in_ready;
		mul_sel_t  mul_sel;
		acc_op_t   acc_op;
		acc_sh_t   acc_sh;
		logic      ld_aa;
		logic      ld_bb;
		logic      ld_tmp;
		logic      inc_x;
		logic      dec_y;
		logic      set_r2;
		logic      emit_valid;
		logic      emit_last;
		logic      run_end;
		logic [1:0] pt_idx;
	} ctrl_t;

	typedef struct packed {
		logic lt;
		logic dec_pos;
		logic active;
		logic in_r2;
	} status_t;

endpackage

// ----- design/mer_mul.sv -----
// shared multiplier with registered product
module mer_mul #(
	parameter int MW = 22
) (
	input  logic            clk,
	input  logic [MW-1:0]   op_a,
	input  logic [MW-1:0]   op_b,
	output logic [2*MW-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= (2*MW)'(op_a) * (2*MW)'(op_b);
	end

endmodule

// ----- design/mer_acc.sv -----
// decision accumulator: load, add or subtract a shifted product
module mer_acc #(
	parameter int PW = 44
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mer_pkg::acc_op_t acc_op,
	input  mer_pkg::acc_sh_t acc_sh,
	input  logic [PW-1:0]    prod,
	output logic             dec_pos
);

	mer_pkg::dec_t dec_q;
	mer_pkg::dec_t prod_ext;
	mer_pkg::dec_t addend;

	assign prod_ext = mer_pkg::dec_t'(prod);

	always_comb begin
		unique case (acc_sh)
			mer_pkg::SH_2: addend = prod_ext << 2;
			mer_pkg::SH_3: addend = prod_ext << 3;
			default:       addend = prod_ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= '0;
		end else begin
			unique case (acc_op)
				mer_pkg::ACC_LOAD: dec_q <= addend;
				mer_pkg::ACC_ADD:  dec_q <= dec_q + addend;
				mer_pkg::ACC_SUB:  dec_q <= dec_q - addend;
				default:           dec_q <= dec_q;
			endcase
		end
	end

	// strictly positive in two's complement
	assign dec_pos = (dec_q != '0) && !dec_q[mer_pkg::DEC_BITS-1];

endmodule

// ----- design/mer_seq.sv -----
// sequencer driving the shared multiplier and accumulator
module mer_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	input  logic             out_ready,
	input  mer_pkg::status_t status,
	output mer_pkg::ctrl_t   ctrl
);

	mer_pkg::state_t state_q;
	mer_pkg::state_t state_d;
	logic [1:0]      idx_q;
	logic            pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
			idx_q   <= '0;
			pos_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// sign of the decision before this step's update
			if (state_q == mer_pkg::ST_R1C || state_q == mer_pkg::ST_R2A) begin
				pos_q <= status.dec_pos;
			end
			if (ctrl.emit_valid && out_ready) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		ctrl            = '0;
		ctrl.mul_sel    = mer_pkg::M_A_A;
		ctrl.acc_op     = mer_pkg::ACC_NONE;
		ctrl.acc_sh     = mer_pkg::SH_0;
		ctrl.pt_idx     = idx_q;
		unique case (state_q)
			mer_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == mer_pkg::KIND_START) begin
						state_d = mer_pkg::ST_SQA;
					end else if (status.active) begin
						state_d = status.in_r2 ? mer_pkg::ST_R2A : mer_pkg::ST_R1L;
					end
				end
			end
			// start: d = aa + 4bb - 4aa*b
			mer_pkg::ST_SQA: begin
				ctrl.mul_sel = mer_pkg::M_A_A;
				state_d      = mer_pkg::ST_SQB;
			end
			mer_pkg::ST_SQB: begin
				ctrl.ld_aa   = 1'b1;
				ctrl.acc_op  = mer_pkg::ACC_LOAD;
				ctrl.mul_sel = mer_pkg::M_B_B;
				state_d      = mer_pkg::ST_AB;
			end
			mer_pkg::ST_AB: begin
				ctrl.ld_bb   = 1'b1;
				ctrl.acc_op  = mer_pkg::ACC_ADD;
				ctrl.acc_sh  = mer_pkg::SH_2;
				ctrl.mul_sel = mer_pkg::M_AA_B;
				state_d      = mer_pkg::ST_INIT;
			end
			mer_pkg::ST_INIT: begin
				ctrl.acc_op = mer_pkg::ACC_SUB;
				ctrl.acc_sh = mer_pkg::SH_2;
				state_d     = mer_pkg::ST_EMIT;
			end
			// region one test: 2bb(x+1) < aa(2y-1)
			mer_pkg::ST_R1L: begin
				ctrl.mul_sel = mer_pkg::M_BB_X1;
				state_d      = mer_pkg::ST_R1R;
			end
			mer_pkg::ST_R1R: begin
				ctrl.ld_tmp  = 1'b1;
				ctrl.mul_sel = mer_pkg::M_AA_2YM1;
				state_d      = mer_pkg::ST_R1C;
			end
			mer_pkg::ST_R1C: begin
				ctrl.mul_sel = mer_pkg::M_BB_2X3;
				state_d      = status.lt ? mer_pkg::ST_R1B : mer_pkg::ST_T1;
			end
			mer_pkg::ST_R1B: begin
				ctrl.acc_op  = mer_pkg::ACC_ADD;
				ctrl.acc_sh  = mer_pkg::SH_2;
				ctrl.mul_sel = mer_pkg::M_AA_YM1;
				state_d      = mer_pkg::ST_R1D;
			end
			mer_pkg::ST_R1D: begin
				ctrl.acc_op = pos_q ? mer_pkg::ACC_SUB : mer_pkg::ACC_NONE;
				ctrl.acc_sh = mer_pkg::SH_3;
				ctrl.inc_x  = 1'b1;
				ctrl.dec_y  = pos_q;
				state_d     = mer_pkg::ST_EMIT;
			end
			// region two entry: d = bb(2x+1)^2 + 4aa(y-1)^2 - 4aa*bb
			mer_pkg::ST_T1: begin
				ctrl.mul_sel = mer_pkg::M_TX_TX;
				state_d      = mer_pkg::ST_T2;
			end
			mer_pkg::ST_T2: begin
				ctrl.ld_tmp  = 1'b1;
				ctrl.mul_sel = mer_pkg::M_TY_TY;
				state_d      = mer_pkg::ST_T3;
			end
			mer_pkg::ST_T3: begin
				ctrl.ld_tmp  = 1'b1;
				ctrl.mul_sel = mer_pkg::M_BB_TMP;
				state_d      = mer_pkg::ST_T4;
			end
			mer_pkg::ST_T4: begin
				ctrl.acc_op  = mer_pkg::ACC_LOAD;
				ctrl.mul_sel = mer_pkg::M_AA_TMP;
				state_d      = mer_pkg::ST_T5;
			end
			mer_pkg::ST_T5: begin
				ctrl.acc_op  = mer_pkg::ACC_ADD;
				ctrl.acc_sh  = mer_pkg::SH_2;
				ctrl.mul_sel = mer_pkg::M_AA_BB;
				state_d      = mer_pkg::ST_T6;
			end
			mer_pkg::ST_T6: begin
				ctrl.acc_op = mer_pkg::ACC_SUB;
				ctrl.acc_sh = mer_pkg::SH_2;
				ctrl.set_r2 = 1'b1;
				state_d     = mer_pkg::ST_R2A;
			end
			// region two step: d += 12aa - 8aa*y, plus 8bb(x+1) when not positive
			mer_pkg::ST_R2A: begin
				ctrl.mul_sel = mer_pkg::M_AA_Y;
				state_d      = mer_pkg::ST_R2B;
			end
			mer_pkg::ST_R2B: begin
				ctrl.acc_op  = mer_pkg::ACC_SUB;
				ctrl.acc_sh  = mer_pkg::SH_3;
				ctrl.mul_sel = mer_pkg::M_AA_3;
				state_d      = mer_pkg::ST_R2C;
			end
			mer_pkg::ST_R2C: begin
				ctrl.acc_op  = mer_pkg::ACC_ADD;
				ctrl.acc_sh  = mer_pkg::SH_2;
				ctrl.mul_sel = mer_pkg::M_BB_X1;
				state_d      = mer_pkg::ST_R2D;
			end
			mer_pkg::ST_R2D: begin
				ctrl.acc_op = pos_q ? mer_pkg::ACC_NONE : mer_pkg::ACC_ADD;
				ctrl.acc_sh = mer_pkg::SH_3;
				ctrl.inc_x  = !pos_q;
				ctrl.dec_y  = 1'b1;
				state_d     = mer_pkg::ST_EMIT;
			end
			mer_pkg::ST_EMIT: begin
				ctrl.emit_valid = 1'b1;
				ctrl.emit_last  = (idx_q == mer_pkg::LAST_IDX);
				if (out_ready && idx_q == mer_pkg::LAST_IDX) begin
					ctrl.run_end = 1'b1;
					state_d      = mer_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mer_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/midpoint_ellipse_rasterizer.sv -----
// midpoint ellipse rasterizer top level: state registers, operand select, output words
//
// input stream (s_*): one word per command. s_tuser is the kind (start or advance),
// s_tdata carries the two semi-axes. a start loads the axes and yields the four
// mirrored copies of (0,b); an advance runs one midpoint iteration and yields four
// mirrored points. an advance while idle yields nothing.
// output stream (m_*): four words per command, tlast on the fourth, tuser set on all
// four when y has reached 0, after which the ellipse is finished.
// all arithmetic goes through one registered multiplier and one accumulator under a
// sequencer, so the block takes one command at a time and s_tready is low meanwhile.
// the multiplier passes from accepted word to first result word depend on the command:
//   start, region-one step, step leaving region one, region-two step.
//   an advance while idle yields no words and leaves s_tready high, so the next
//   command can be taken in the following cycle. otherwise the four result words go
//   out, and the next command is taken in the cycle after the fourth goes out.
// a stalled receiver simply holds the current word; nothing is lost or dropped.
// reset clears the walker, the decision value and the active flag, so the block
// comes up idle and waits for a start.
module midpoint_ellipse_rasterizer #(
	parameter  int COORD_BITS = 10,
	localparam int S_W = ((2*COORD_BITS + 7) / 8) * 8,
	localparam int M_W = ((2*(COORD_BITS + 1) + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [S_W-1:0] s_tdata,   // semi_axis_a, semi_axis_b
	input  logic           s_tuser,   // kind
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [M_W-1:0] m_tdata,   // point_x, point_y
	output logic           m_tlast,
	output logic           m_tuser    // ellipse_done
);

	localparam int C  = COORD_BITS;
	localparam int OW = COORD_BITS + 1;
	localparam int MW = 2*COORD_BITS + 2;
	localparam int PW = 2*MW;

	mer_pkg::ctrl_t   ctrl;
	mer_pkg::status_t status;
	logic             dec_pos;

	logic [C-1:0]    axis_a_q;
	logic [C-1:0]    axis_b_q;
	logic [2*C-1:0]  aa_q;
	logic [2*C-1:0]  bb_q;
	logic [PW-1:0]   tmp_q;
	logic [C-1:0]    cur_x_q;
	logic [C-1:0]    cur_y_q;
	logic            in_r2_q;
	logic            active_q;

	logic [MW-1:0]   op_a;
	logic [MW-1:0]   op_b;
	logic [PW-1:0]   prod;
	logic            in_acc;
	logic            start_acc;

	logic [MW-1:0]   x_e;
	logic [MW-1:0]   y_e;
	logic [MW-1:0]   aa_e;
	logic [MW-1:0]   bb_e;
	logic [OW-1:0]   px_e;
	logic [OW-1:0]   py_e;
	logic [OW-1:0]   point_x;
	logic [OW-1:0]   point_y;
	logic            neg_x;
	logic            neg_y;

	assign in_acc    = s_tvalid && s_tready;
	assign start_acc = in_acc && (s_tuser == mer_pkg::KIND_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_a_q <= '0;
			axis_b_q <= '0;
			aa_q     <= '0;
			bb_q     <= '0;
			tmp_q    <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			in_r2_q  <= 1'b0;
			active_q <= 1'b0;
		end else begin
			if (start_acc) begin
				axis_a_q <= s_tdata[C-1:0];
				axis_b_q <= s_tdata[2*C-1:C];
				cur_x_q  <= '0;
				cur_y_q  <= s_tdata[2*C-1:C];
				in_r2_q  <= 1'b0;
				active_q <= 1'b1;
			end else begin
				if (ctrl.inc_x) begin
					cur_x_q <= cur_x_q + 1'b1;
				end
				if (ctrl.dec_y) begin
					cur_y_q <= cur_y_q - 1'b1;
				end
				if (ctrl.set_r2) begin
					in_r2_q <= 1'b1;
				end
				// the run that brings y to 0 ends the ellipse
				if (ctrl.run_end && cur_y_q == '0) begin
					active_q <= 1'b0;
				end
			end
			if (ctrl.ld_aa) begin
				aa_q <= prod[2*C-1:0];
			end
			if (ctrl.ld_bb) begin
				bb_q <= prod[2*C-1:0];
			end
			if (ctrl.ld_tmp) begin
				tmp_q <= prod;
			end
		end
	end

	assign x_e  = MW'(cur_x_q);
	assign y_e  = MW'(cur_y_q);
	assign aa_e = MW'(aa_q);
	assign bb_e = MW'(bb_q);

	always_comb begin
		op_a = MW'(axis_a_q);
		op_b = MW'(axis_a_q);
		unique case (ctrl.mul_sel)
			mer_pkg::M_A_A: begin
				op_a = MW'(axis_a_q);
				op_b = MW'(axis_a_q);
			end
			mer_pkg::M_B_B: begin
				op_a = MW'(axis_b_q);
				op_b = MW'(axis_b_q);
			end
			mer_pkg::M_AA_B: begin
				op_a = aa_e;
				op_b = MW'(axis_b_q);
			end
			mer_pkg::M_BB_X1: begin
				op_a = bb_e;
				op_b = x_e + 1'b1;
			end
			mer_pkg::M_AA_2YM1: begin
				op_a = aa_e;
				op_b = (y_e << 1) - 1'b1;
			end
			mer_pkg::M_BB_2X3: begin
				op_a = bb_e;
				op_b = (x_e << 1) + MW'(3);
			end
			mer_pkg::M_AA_YM1: begin
				op_a = aa_e;
				op_b = y_e - 1'b1;
			end
			mer_pkg::M_TX_TX: begin
				op_a = (x_e << 1) + 1'b1;
				op_b = (x_e << 1) + 1'b1;
			end
			mer_pkg::M_TY_TY: begin
				op_a = y_e - 1'b1;
				op_b = y_e - 1'b1;
			end
			mer_pkg::M_BB_TMP: begin
				op_a = bb_e;
				op_b = tmp_q[MW-1:0];
			end
			mer_pkg::M_AA_TMP: begin
				op_a = aa_e;
				op_b = tmp_q[MW-1:0];
			end
			mer_pkg::M_AA_BB: begin
				op_a = aa_e;
				op_b = bb_e;
			end
			mer_pkg::M_AA_Y: begin
				op_a = aa_e;
				op_b = y_e;
			end
			mer_pkg::M_AA_3: begin
				op_a = aa_e;
				op_b = MW'(3);
			end
			default: begin
				op_a = aa_e;
				op_b = bb_e;
			end
		endcase
	end

	mer_mul #(
		.MW(MW)
	) u_mul (
		.clk   (clk),
		.op_a  (op_a),
		.op_b  (op_b),
		.prod_q(prod)
	);

	mer_acc #(
		.PW(PW)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.acc_op (ctrl.acc_op),
		.acc_sh (ctrl.acc_sh),
		.prod   (prod),
		.dec_pos(dec_pos)
	);

	// region-one test, lhs held in tmp and doubled here
	assign status.lt      = {tmp_q, 1'b0} < {1'b0, prod};
	assign status.dec_pos = dec_pos;
	assign status.active  = active_q;
	assign status.in_r2   = in_r2_q;

	mer_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.out_ready(m_tready),
		.status   (status),
		.ctrl     (ctrl)
	);

	// mirror order: (x,y), (-x,-y), (-x,y), (x,-y)
	assign neg_x   = ctrl.pt_idx[0] ^ ctrl.pt_idx[1];
	assign neg_y   = ctrl.pt_idx[0];
	assign px_e    = OW'(cur_x_q);
	assign py_e    = OW'(cur_y_q);
	assign point_x = neg_x ? (OW'(0) - px_e) : px_e;
	assign point_y = neg_y ? (OW'(0) - py_e) : py_e;

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = ctrl.emit_valid;
	assign m_tdata  = M_W'({point_y, point_x});
	assign m_tlast  = ctrl.emit_last;
	assign m_tuser  = (cur_y_q == '0);

endmodule

// ----- design/mer_checker.sv -----
// port-level checker for the ellipse rasterizer, bound to the top level
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_checker #(
	parameter  int COORD_BITS = 10,
	localparam int M_W = ((2*(COORD_BITS + 1) + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           s_tuser,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [M_W-1:0] m_tdata,
	input logic           m_tlast,
	input logic           m_tuser
);

	// the block either takes a command or delivers words, never both
	`MER_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid))

	// a start keeps the block busy in the following cycle
	`MER_ASSERT_NEXT(a_start_busy, s_tvalid && s_tready && s_tuser == mer_pkg::KIND_START, !s_tready)

	// after the fourth word of a run the output goes quiet
	`MER_ASSERT_NEXT(a_run_ends, m_tvalid && m_tready && m_tlast, !m_tvalid)

	// the done flag is the same on every word of one run
	`MER_ASSERT_NEXT(a_done_steady, m_tvalid && m_tready && !m_tlast, m_tuser == $past(m_tuser))

	// a stalled word holds
	`MER_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (.*);
